FILE: rtl/core/sce_pkg.sv
// ----------------------------------------------------------------------------
// sce_pkg
// Shared widths, codes and types of the cumulative energy stage.
// ----------------------------------------------------------------------------
package sce_pkg;

   localparam int MAX_COLS_DEFAULT = 2048;
   localparam int CSR_W            = 12;
   localparam int ENERGY_W         = 16;
   localparam int CUM_W            = 32;
   localparam int DIR_W            = 2;
   localparam int OUTQ_DEPTH       = 3;

   localparam logic [CSR_W-1:0] IMAGE_WIDTH_RESET = 12'd2048;

   localparam logic signed [DIR_W-1:0] DIR_LEFT     = 2'sb11;
   localparam logic signed [DIR_W-1:0] DIR_STRAIGHT = 2'sb00;
   localparam logic signed [DIR_W-1:0] DIR_RIGHT    = 2'sb01;

   typedef struct packed {
      logic bottom;
      logic first_col;
      logic last_col;
   } sce_ctl_type;

   typedef struct packed {
      logic [CUM_W-1:0]        cum_energy;
      logic signed [DIR_W-1:0] direction;
      logic                    row_end;
   } sce_rsp_type;

endpackage

FILE: rtl/core/seam_cumulative_energy_dp.sv
// ----------------------------------------------------------------------------
// seam_cumulative_energy_dp
// Streaming seam carving cumulative energy stage with a one-row line store.
//
//   port group  direction  contents
//   req_        in         pixel_energy, new_image; valid / stall
//   rsp_        out        cumulative_energy, direction, row_end; valid / stall
//   csr_        in         image_width write (enable, data)
//
// One request per cycle sustained unless the request side stalls; results pass
// the compute stage and the result queue. The line store is read at the column
// and its right neighbour while the previous pixel writes back; a write to a
// column just read is forwarded. Reset needs no store clearing pass. The
// request side stalls only when the three-entry result queue could overflow.
// ----------------------------------------------------------------------------
module seam_cumulative_energy_dp #(
   parameter int MAX_COLS = sce_pkg::MAX_COLS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [sce_pkg::ENERGY_W-1:0]       req_pixel_energy,
   input  logic                               req_new_image,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sce_pkg::CUM_W-1:0]          rsp_cumulative_energy,
   output logic signed [sce_pkg::DIR_W-1:0]   rsp_direction,
   output logic                               rsp_row_end,
   input  logic                               csr_wr_en,
   input  logic [sce_pkg::CSR_W-1:0]          csr_wr_data
);
   import sce_pkg::*;

   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int Q_CNT_W = $clog2(OUTQ_DEPTH + 1);

   logic [CSR_W-1:0]    image_width_ff;
   logic [COL_W-1:0]    last_col;

   logic [COL_W-1:0]    col_ff, col_in;
   logic                bottom_ff, bottom_in;
   logic [COL_W-1:0]    col_base;
   logic                bottom_cur;
   logic [COL_W-1:0]    col_cur;
   logic                is_last;
   logic [COL_W-1:0]    rd_right;
   logic                accept;

   logic                s1_valid_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic                s1_last_ff;
   logic                s1_bottom_ff;
   logic [ENERGY_W-1:0] s1_energy_ff;
   logic                s1_fwd_c_ff;
   logic                s1_fwd_r_ff;
   logic [CUM_W-1:0]    s1_fwd_data_ff;

   logic [CUM_W-1:0]    held_left_ff, held_left_in;
   logic [CUM_W-1:0]    rd_center_data;
   logic [CUM_W-1:0]    rd_right_data;
   logic [CUM_W-1:0]    center;
   logic [CUM_W-1:0]    right;
   sce_ctl_type         s1_ctl;
   sce_rsp_type         s1_rsp;

   sce_rsp_type         q_head;
   logic [Q_CNT_W-1:0]  q_count;
   logic                q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= IMAGE_WIDTH_RESET;
      end else if (csr_wr_en) begin
         image_width_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (image_width_ff < CSR_W'(2)) begin
         last_col = COL_W'(1);
      end else if (32'(image_width_ff) > 32'(MAX_COLS)) begin
         last_col = COL_W'(MAX_COLS - 1);
      end else begin
         last_col = COL_W'(image_width_ff - CSR_W'(1));
      end
   end

   assign req_stall = (32'(q_count) + 32'(s1_valid_ff)) >= 32'(OUTQ_DEPTH);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      col_base   = req_new_image ? '0 : col_ff;
      bottom_cur = req_new_image | bottom_ff;
      col_cur    = (col_base >= last_col) ? last_col : col_base;
      is_last    = (col_cur == last_col);
      rd_right   = is_last ? col_cur : col_cur + COL_W'(1);
      col_in     = col_ff;
      bottom_in  = bottom_ff;
      if (accept) begin
         col_in    = is_last ? '0 : col_cur + COL_W'(1);
         bottom_in = is_last ? 1'b0 : bottom_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         bottom_ff    <= 1'b1;
         s1_valid_ff  <= 1'b0;
         held_left_ff <= '0;
      end else begin
         col_ff       <= col_in;
         bottom_ff    <= bottom_in;
         s1_valid_ff  <= accept;
         held_left_ff <= held_left_in;
      end
   end

   // capture the request and forward the write that lands in the read cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff      <= col_cur;
         s1_last_ff     <= is_last;
         s1_bottom_ff   <= bottom_cur;
         s1_energy_ff   <= req_pixel_energy;
         s1_fwd_c_ff    <= s1_valid_ff && (s1_col_ff == col_cur);
         s1_fwd_r_ff    <= s1_valid_ff && (s1_col_ff == rd_right);
         s1_fwd_data_ff <= s1_rsp.cum_energy;
      end
   end

   sce_ram #(
      .WIDTH (CUM_W),
      .DEPTH (MAX_COLS)
   ) u_row_store (
      .clock     (clock),
      .wr_en     (s1_valid_ff),
      .wr_addr   (s1_col_ff),
      .wr_data   (s1_rsp.cum_energy),
      .rd_en     (accept),
      .rd_addr_a (col_cur),
      .rd_addr_b (rd_right),
      .rd_data_a (rd_center_data),
      .rd_data_b (rd_right_data)
   );

   always_comb begin
      center           = s1_fwd_c_ff ? s1_fwd_data_ff : rd_center_data;
      right            = s1_fwd_r_ff ? s1_fwd_data_ff : rd_right_data;
      s1_ctl.bottom    = s1_bottom_ff;
      s1_ctl.first_col = (s1_col_ff == '0);
      s1_ctl.last_col  = s1_last_ff;
      held_left_in     = (s1_valid_ff && !s1_bottom_ff) ? center : held_left_ff;
   end

   sce_pick u_pick (
      .ctl    (s1_ctl),
      .energy (s1_energy_ff),
      .left   (held_left_ff),
      .center (center),
      .right  (right),
      .res    (s1_rsp)
   );

   assign q_pop = rsp_valid && !rsp_stall;

   sce_outq #(
      .DEPTH (OUTQ_DEPTH)
   ) u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (s1_rsp),
      .pop       (q_pop),
      .head      (q_head),
      .count     (q_count)
   );

   assign rsp_valid             = (q_count != '0);
   assign rsp_cumulative_energy = q_head.cum_energy;
   assign rsp_direction         = q_head.direction;
   assign rsp_row_end           = q_head.row_end;

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted request did not enter the compute stage");

   a_queue_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(q_count) <= 32'(OUTQ_DEPTH))
      else $error("result queue overflow");

   a_bottom_straight: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_bottom_ff) |-> (s1_rsp.direction == DIR_STRAIGHT))
      else $error("bottom row pixel with a turn");

   a_forward_source: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_valid_ff && (s1_col_ff == col_cur)) |=> s1_fwd_c_ff)
      else $error("store write not forwarded to the center read");

endmodule

FILE: rtl/core/sce_ram.sv
// ----------------------------------------------------------------------------
// sce_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module sce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: rtl/core/sce_pick.sv
// ----------------------------------------------------------------------------
// sce_pick
// Choose the cheapest of up to three neighbours below and add the pixel energy.
// ----------------------------------------------------------------------------
module sce_pick (
   input  sce_pkg::sce_ctl_type            ctl,
   input  logic [sce_pkg::ENERGY_W-1:0]    energy,
   input  logic [sce_pkg::CUM_W-1:0]       left,
   input  logic [sce_pkg::CUM_W-1:0]       center,
   input  logic [sce_pkg::CUM_W-1:0]       right,
   output sce_pkg::sce_rsp_type            res
);
   import sce_pkg::*;

   logic [CUM_W-1:0]        best;
   logic signed [DIR_W-1:0] dir;
   logic [CUM_W:0]          sum;

   always_comb begin
      best = center;
      dir  = DIR_STRAIGHT;
      if (!ctl.first_col && (left <= best)) begin
         best = left;
         dir  = DIR_LEFT;
      end
      if (!ctl.last_col && (right < best)) begin
         best = right;
         dir  = DIR_RIGHT;
      end
      sum = {1'b0, best} + {{(CUM_W + 1 - ENERGY_W){1'b0}}, energy};

      res.row_end = ctl.last_col;
      if (ctl.bottom) begin
         res.cum_energy = {{(CUM_W - ENERGY_W){1'b0}}, energy};
         res.direction  = DIR_STRAIGHT;
      end else begin
         res.cum_energy = sum[CUM_W] ? {CUM_W{1'b1}} : sum[CUM_W-1:0];
         res.direction  = dir;
      end
   end

endmodule

FILE: rtl/core/sce_outq.sv
// ----------------------------------------------------------------------------
// sce_outq
// Small result queue that decouples the pipeline from the response stall.
// ----------------------------------------------------------------------------
module sce_outq #(
   parameter int DEPTH = sce_pkg::OUTQ_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sce_pkg::sce_rsp_type       push_data,
   input  logic                       pop,
   output sce_pkg::sce_rsp_type       head,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import sce_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sce_rsp_type      entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule
